@@ hw/rtl/gpk_pkg.sv @@
package gpk_pkg;

  localparam int MAX_PAIRS  = 1024;
  localparam int IDX_W      = $clog2(MAX_PAIRS);
  localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
  localparam int GLYPH_W    = 16;
  localparam int ADV_W      = 32;
  localparam int KEY_W      = 2 * GLYPH_W;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_GLYPH  = 2'd2;

  // Rounding of an adjustment to whole pixels in 26.6.
  localparam logic [ADV_W-1:0] ROUND_HALF = 32'd32;
  localparam logic [ADV_W-1:0] PIXEL_MASK = 32'hFFFF_FFC0;

  typedef struct packed {
    logic take;
    logic probe;
    logic emit_held;
    logic emit_cur;
  } gpk_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic cur_last;
    logic probe_live;
    logic hit;
    logic slot_free;
  } gpk_sts_t;

endpackage

@@ hw/rtl/gpk_ctrl.sv @@
module gpk_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [gpk_pkg::OP_W-1:0]  in_op,
  input  logic                      in_last,
  input  gpk_pkg::gpk_sts_t         sts,
  output gpk_pkg::gpk_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_PROBE     = 2'd1;
  localparam logic [1:0] ST_EMIT_HELD = 2'd2;
  localparam logic [1:0] ST_EMIT_LAST = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.take      = 1'b0;
    cmd.probe     = 1'b0;
    cmd.emit_held = 1'b0;
    cmd.emit_cur  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_op == gpk_pkg::OP_GLYPH) begin
            if (sts.held_valid) begin
              state_nxt = sts.probe_live ? ST_PROBE : ST_EMIT_HELD;
            end else if (in_last) begin
              state_nxt = ST_EMIT_LAST;
            end
          end
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit || !sts.probe_live) begin
          state_nxt = ST_EMIT_HELD;
        end
      end
      ST_EMIT_HELD: begin
        if (sts.slot_free) begin
          cmd.emit_held = 1'b1;
          state_nxt     = sts.cur_last ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (sts.slot_free) begin
          cmd.emit_cur = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/gpk_dp.sv @@
module gpk_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gpk_pkg::gpk_cmd_t             cmd,
  output gpk_pkg::gpk_sts_t             sts,
  input  logic [gpk_pkg::OP_W-1:0]      in_op,
  input  logic [gpk_pkg::GLYPH_W-1:0]   in_pair_left,
  input  logic [gpk_pkg::GLYPH_W-1:0]   in_pair_right,
  input  logic [gpk_pkg::ADV_W-1:0]     in_pair_adjust,
  input  logic [gpk_pkg::GLYPH_W-1:0]   in_glyph_id,
  input  logic [gpk_pkg::ADV_W-1:0]     in_glyph_advance,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpk_pkg::GLYPH_W-1:0]   out_glyph,
  output logic [gpk_pkg::ADV_W-1:0]     out_advance,
  output logic                          out_last
);

  localparam int ENTRY_W = gpk_pkg::ADV_W + gpk_pkg::KEY_W;

  // Each entry holds the adjustment above the key.
  logic [ENTRY_W-1:0] pair_mem [gpk_pkg::MAX_PAIRS];
  logic [ENTRY_W-1:0] rd_q;

  logic [gpk_pkg::CNT_W-1:0]   count_r;
  logic [gpk_pkg::CNT_W-1:0]   lo_r, lo_nxt;
  logic [gpk_pkg::CNT_W-1:0]   hie_r, hie_nxt;
  logic [gpk_pkg::CNT_W-1:0]   mid_r, mid_nxt;
  logic [gpk_pkg::KEY_W-1:0]   key_r;
  logic [gpk_pkg::ADV_W-1:0]   adj_r;
  logic                        hit;
  logic                        wr_en;

  logic                        held_valid_r;
  logic [gpk_pkg::GLYPH_W-1:0] held_glyph_r;
  logic [gpk_pkg::ADV_W-1:0]   held_adv_r;
  logic [gpk_pkg::GLYPH_W-1:0] cur_glyph_r;
  logic [gpk_pkg::ADV_W-1:0]   cur_adv_r;
  logic                        cur_last_r;

  logic                        out_valid_r;
  logic [gpk_pkg::GLYPH_W-1:0] out_glyph_r;
  logic [gpk_pkg::ADV_W-1:0]   out_adv_r;
  logic                        out_last_r;
  logic                        slot_free;
  logic [gpk_pkg::ADV_W-1:0]   rounded;
  logic                        is_glyph;

  wire [gpk_pkg::KEY_W-1:0] rd_key = rd_q[gpk_pkg::KEY_W-1:0];
  wire [gpk_pkg::ADV_W-1:0] rd_adj = rd_q[ENTRY_W-1:gpk_pkg::KEY_W];

  assign is_glyph  = (in_op == gpk_pkg::OP_GLYPH);
  assign slot_free = !out_valid_r || out_ready;
  assign wr_en     = cmd.take && (in_op == gpk_pkg::OP_APPEND)
                     && (count_r < gpk_pkg::CNT_W'(gpk_pkg::MAX_PAIRS));

  // Search bounds: lo is inclusive, hie is exclusive.
  always_comb begin
    lo_nxt  = lo_r;
    hie_nxt = hie_r;
    hit     = 1'b0;
    if (cmd.take) begin
      lo_nxt  = '0;
      hie_nxt = count_r;
    end else if (cmd.probe) begin
      if (rd_key == key_r) begin
        hit = 1'b1;
      end else if (rd_key < key_r) begin
        lo_nxt = mid_r + gpk_pkg::CNT_W'(1);
      end else begin
        hie_nxt = mid_r;
      end
    end
    mid_nxt = lo_nxt + ((hie_nxt - lo_nxt - gpk_pkg::CNT_W'(1)) >> 1);
  end

  assign sts.held_valid = held_valid_r;
  assign sts.cur_last   = cur_last_r;
  assign sts.probe_live = lo_nxt < hie_nxt;
  assign sts.hit        = hit;
  assign sts.slot_free  = slot_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pair_mem[count_r[gpk_pkg::IDX_W-1:0]] <= {in_pair_adjust, in_pair_left, in_pair_right};
    end
    rd_q <= pair_mem[mid_nxt[gpk_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hie_r <= hie_nxt;
    mid_r <= mid_nxt;
    if (cmd.take) begin
      key_r <= {held_glyph_r, in_glyph_id};
      adj_r <= '0;
    end else if (hit) begin
      adj_r <= rd_adj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.take && (in_op == gpk_pkg::OP_CLEAR)) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + gpk_pkg::CNT_W'(1);
    end
  end

  // A glyph stays held until its successor has been through the search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (cmd.take && is_glyph && !held_valid_r) begin
      held_valid_r <= !in_last;
    end else if (cmd.emit_held) begin
      held_valid_r <= !cur_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_glyph && !held_valid_r) begin
      held_glyph_r <= in_glyph_id;
      held_adv_r   <= in_glyph_advance;
    end else if (cmd.emit_held) begin
      held_glyph_r <= cur_glyph_r;
      held_adv_r   <= cur_adv_r;
    end
    if (cmd.take && is_glyph) begin
      cur_glyph_r <= in_glyph_id;
      cur_adv_r   <= in_glyph_advance;
      cur_last_r  <= in_last;
    end
  end

  assign rounded = (adj_r + gpk_pkg::ROUND_HALF) & gpk_pkg::PIXEL_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_held || cmd.emit_cur) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_held) begin
      out_glyph_r <= held_glyph_r;
      out_adv_r   <= held_adv_r + rounded;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_cur) begin
      out_glyph_r <= cur_glyph_r;
      out_adv_r   <= cur_adv_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_glyph   = out_glyph_r;
  assign out_advance = out_adv_r;
  assign out_last    = out_last_r;

endmodule

@@ hw/rtl/glyph_pair_kerning_core.sv @@
// Clear, append and a glyph that causes no result leave the controller idle.
// A glyph that follows a held glyph is taken, then probes the table one probe
// at a time (at most 11 probes for 1024 pairs, over the single pair memory read
// port), then loads each result into the output register once that is free.
// Results are shown from the output register, which lets the next request in
// while a result waits. Synchronous active-low reset empties the table, drops
// the held glyph and clears the output valid flag.
module glyph_pair_kerning_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pair_left, pair_right, pair_adjust, glyph_id, glyph_advance
  input  logic [gpk_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic [gpk_pkg::OP_W-1:0]         in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_glyph, out_advance
  output logic [gpk_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast
);

  gpk_pkg::gpk_cmd_t cmd;
  gpk_pkg::gpk_sts_t sts;

  logic [gpk_pkg::GLYPH_W-1:0] out_glyph;
  logic [gpk_pkg::ADV_W-1:0]   out_advance;

  gpk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_last   (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  gpk_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_tuser),
    .in_pair_left     (in_tdata[15:0]),
    .in_pair_right    (in_tdata[31:16]),
    .in_pair_adjust   (in_tdata[63:32]),
    .in_glyph_id      (in_tdata[79:64]),
    .in_glyph_advance (in_tdata[111:80]),
    .in_last          (in_tlast),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_glyph        (out_glyph),
    .out_advance      (out_advance),
    .out_last         (out_tlast)
  );

  assign out_tdata = {out_advance, out_glyph};

endmodule

@@ hw/rtl/gpk_checker.sv @@
module gpk_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [gpk_pkg::OP_W-1:0]       in_tuser,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gpk_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == gpk_pkg::OP_GLYPH && in_tlast |=> !in_tready)
    else $error("last glyph accepted without emitting");

  a_table_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready
    && (in_tuser == gpk_pkg::OP_CLEAR || in_tuser == gpk_pkg::OP_APPEND) |=> in_tready)
    else $error("table request stalled the input");

endmodule

bind glyph_pair_kerning_core gpk_checker u_gpk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/glyph_pair_kerning_core_test.sv @@
`timescale 1ns / 1ps

module glyph_pair_kerning_core_test;

  localparam logic [gpk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [gpk_pkg::ADV_W-1:0] HALF_PIXEL = 32'd32;
  localparam logic [gpk_pkg::ADV_W-1:0] WHOLE_PIXEL_MASK = 32'hFFFF_FFC0;
  localparam int TOTAL_REQUESTS = 1200;
  localparam int OVERFILL = 6;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [gpk_pkg::OP_W-1:0]    op;
    logic [gpk_pkg::GLYPH_W-1:0] left;
    logic [gpk_pkg::GLYPH_W-1:0] right;
    logic [gpk_pkg::ADV_W-1:0]   adjust;
    logic [gpk_pkg::GLYPH_W-1:0] glyph;
    logic [gpk_pkg::ADV_W-1:0]   advance;
    logic                        last;
    int unsigned                 gap;
    int unsigned                 out_stall_max;
  } request_t;

  typedef struct packed {
    logic [gpk_pkg::GLYPH_W-1:0] glyph;
    logic [gpk_pkg::ADV_W-1:0]   advance;
    logic                        last;
  } kerned_glyph_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [gpk_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [gpk_pkg::OP_W-1:0]       in_tuser = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [gpk_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;

  glyph_pair_kerning_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Kerning table and held glyph as the block should see them.
  logic [gpk_pkg::KEY_W-1:0]   pair_keys [gpk_pkg::MAX_PAIRS];
  logic [gpk_pkg::ADV_W-1:0]   pair_adjusts [gpk_pkg::MAX_PAIRS];
  int                          pair_count = 0;
  logic                        held_valid = 1'b0;
  logic [gpk_pkg::GLYPH_W-1:0] held_glyph = '0;
  logic [gpk_pkg::ADV_W-1:0]   held_advance = '0;

  request_t      pending_requests[$];
  request_t      cur_req;
  kerned_glyph_t kerned_glyphs[$];

  int unsigned in_idle_max = 7;
  int unsigned out_idle_max = 7;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned out_stall_max = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          accepted_requests = 0;
  int          mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [gpk_pkg::ADV_W-1:0] lookup_adjust(
      input logic [gpk_pkg::KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = pair_count - 1;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (pair_keys[mid] == key) begin
        return pair_adjusts[mid];
      end
      if (pair_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return '0;
  endfunction

  task automatic apply_kerning(input request_t r);
    kerned_glyph_t res;
    logic [gpk_pkg::ADV_W-1:0] adj;
    case (r.op)
      gpk_pkg::OP_CLEAR: pair_count = 0;
      gpk_pkg::OP_APPEND: begin
        if (pair_count < gpk_pkg::MAX_PAIRS) begin
          pair_keys[pair_count] = {r.left, r.right};
          pair_adjusts[pair_count] = r.adjust;
          pair_count++;
        end
      end
      gpk_pkg::OP_GLYPH: begin
        if (held_valid) begin
          adj = lookup_adjust({held_glyph, r.glyph});
          res.glyph = held_glyph;
          res.advance = held_advance + ((adj + HALF_PIXEL) & WHOLE_PIXEL_MASK);
          res.last = 1'b0;
          kerned_glyphs.push_back(res);
        end
        if (r.last) begin
          res.glyph = r.glyph;
          res.advance = r.advance;
          res.last = 1'b1;
          kerned_glyphs.push_back(res);
          held_valid = 1'b0;
        end else begin
          held_valid = 1'b1;
          held_glyph = r.glyph;
          held_advance = r.advance;
        end
      end
      default: ;
    endcase
  endtask

  // Fields that the operation does not use carry random bits.
  function automatic request_t random_request(input logic [gpk_pkg::OP_W-1:0] op);
    request_t r;
    r.op = op;
    r.left = gpk_pkg::GLYPH_W'($urandom);
    r.right = gpk_pkg::GLYPH_W'($urandom);
    r.adjust = $urandom;
    r.glyph = gpk_pkg::GLYPH_W'($urandom);
    r.advance = $urandom;
    r.last = 1'($urandom);
    r.gap = $urandom_range(0, in_idle_max);
    r.out_stall_max = out_idle_max;
    return r;
  endfunction

  function automatic void add_op(input logic [gpk_pkg::OP_W-1:0] op);
    pending_requests.push_back(random_request(op));
  endfunction

  function automatic void add_append(input logic [gpk_pkg::GLYPH_W-1:0] left,
                                     input logic [gpk_pkg::GLYPH_W-1:0] right,
                                     input logic [gpk_pkg::ADV_W-1:0] adjust);
    request_t r;
    r = random_request(gpk_pkg::OP_APPEND);
    r.left = left;
    r.right = right;
    r.adjust = adjust;
    pending_requests.push_back(r);
  endfunction

  function automatic void add_glyph(input logic [gpk_pkg::GLYPH_W-1:0] glyph,
                                    input logic [gpk_pkg::ADV_W-1:0] advance,
                                    input logic last);
    request_t r;
    r = random_request(gpk_pkg::OP_GLYPH);
    r.glyph = glyph;
    r.advance = advance;
    r.last = last;
    pending_requests.push_back(r);
  endfunction

  // Small signed values around the rounding points, fully random values and some extremes.
  function automatic logic [gpk_pkg::ADV_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_value = $urandom;
      4: pick_value = 32'h8000_0000;
      5: pick_value = 32'h7FFF_FFE0 + $urandom_range(0, 31);
      6, 7, 8, 9: pick_value = 32'($urandom_range(0, 1023)) - 32'd512;
      default: pick_value = '0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // The request is still waiting for in_tready.
    end else if (in_gap != 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_requests.size() != 0) begin
      cur_req = pending_requests.pop_front();
      in_tdata <= {cur_req.advance, cur_req.glyph, cur_req.adjust, cur_req.right,
                   cur_req.left};
      in_tuser <= cur_req.op;
      in_tlast <= cur_req.last;
      in_tvalid <= 1'b1;
      in_gap <= cur_req.gap;
      out_stall_max <= cur_req.out_stall_max;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_out_ready
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_taken) begin
      stall = $urandom_range(0, out_stall_max);
      out_stall <= stall;
      out_tready <= (stall == 0);
    end else if (out_stall > 1) begin
      out_stall <= out_stall - 1;
    end else begin
      out_stall <= 0;
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    kerned_glyph_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      // A result never comes from a request taken at the same edge.
      if (out_tvalid && out_tready) begin
        if (kerned_glyphs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with none expected: glyph %h advance %h last %b",
                     $realtime, out_tdata[gpk_pkg::GLYPH_W-1:0],
                     out_tdata[gpk_pkg::GLYPH_W +: gpk_pkg::ADV_W], out_tlast);
          end
        end else begin
          want = kerned_glyphs.pop_front();
          if (out_tdata[gpk_pkg::GLYPH_W-1:0] !== want.glyph ||
              out_tdata[gpk_pkg::GLYPH_W +: gpk_pkg::ADV_W] !== want.advance ||
              out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: expected glyph %h advance %h last %b, got glyph %h advance %h last %b",
                       $realtime, want.glyph, want.advance, want.last,
                       out_tdata[gpk_pkg::GLYPH_W-1:0],
                       out_tdata[gpk_pkg::GLYPH_W +: gpk_pkg::ADV_W], out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_kerning(cur_req);
        accepted_requests++;
      end
    end
  end

  initial begin
    logic [gpk_pkg::KEY_W-1:0]   fill_keys [gpk_pkg::MAX_PAIRS + OVERFILL];
    logic [gpk_pkg::KEY_W-1:0]   run_keys[$];
    logic [gpk_pkg::GLYPH_W-1:0] alphabet [8];
    logic [gpk_pkg::GLYPH_W-1:0] pick_glyph;
    logic [gpk_pkg::KEY_W-1:0]   key;
    int                          idx;
    int                          n_pairs;
    int                          n_runs;
    int                          run_len;
    int                          total_requests;

    // Empty table, extreme ids and advances, then a small sorted table whose
    // adjustments hit wraparound in rounding and in the final sum.
    add_glyph(16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    add_glyph(16'h0000, 32'h8000_0000, 1'b0);
    add_glyph(16'hFFFF, 32'h0000_0000, 1'b1);
    add_append(16'h0000, 16'hFFFF, 32'h7FFF_FFE0);
    add_append(16'h0001, 16'h0002, 32'hFFFF_FFDF);
    add_append(16'hFFFF, 16'h0000, 32'h8000_0000);
    add_append(16'hFFFF, 16'hFFFF, 32'h0000_001F);
    add_op(OP_UNUSED);
    add_glyph(16'h0000, 32'h7FFF_FFFF, 1'b0);
    add_glyph(16'hFFFF, 32'h0000_0005, 1'b0);
    add_glyph(16'h0000, 32'h0000_0064, 1'b0);
    add_glyph(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_glyph(16'hFFFF, 32'h0000_0000, 1'b0);
    add_glyph(16'h0001, 32'h0000_0040, 1'b0);
    add_glyph(16'h0002, 32'h0000_0040, 1'b0);
    // A clear leaves the held glyph in place.
    add_op(gpk_pkg::OP_CLEAR);
    add_glyph(16'h0003, 32'h0000_0001, 1'b1);
    // Out-of-order table: the search misses a key that is present.
    add_append(16'h0005, 16'h0005, 32'h0000_0040);
    add_append(16'h0001, 16'h0001, 32'h0000_0080);
    add_glyph(16'h0001, 32'h0000_0007, 1'b0);
    add_glyph(16'h0001, 32'h0000_0009, 1'b1);

    // Fill the table past its size; the last few appends must be dropped.
    add_op(gpk_pkg::OP_CLEAR);
    for (int i = 0; i < gpk_pkg::MAX_PAIRS + OVERFILL; i++) begin
      fill_keys[i] = 32'(i) * 32'd4_000_000 + 32'($urandom_range(0, 3_999_999));
      add_append(fill_keys[i][31:16], fill_keys[i][15:0], pick_value());
    end
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 4))
        0: idx = 0;
        1: idx = gpk_pkg::MAX_PAIRS - 1;
        2: idx = $urandom_range(gpk_pkg::MAX_PAIRS, gpk_pkg::MAX_PAIRS + OVERFILL - 1);
        default: idx = $urandom_range(0, gpk_pkg::MAX_PAIRS - 1);
      endcase
      add_glyph(fill_keys[idx][31:16], pick_value(), 1'b0);
      add_glyph(fill_keys[idx][15:0], pick_value(), 1'($urandom_range(0, 1)));
    end

    // Phases of table loads followed by glyph runs drawn mostly from the
    // same small set of ids, so that pairs often find an entry.
    while (pending_requests.size() < TOTAL_REQUESTS) begin
      in_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      for (int j = 0; j < 8; j++) begin
        if ($urandom_range(0, 2) == 0) begin
          alphabet[j] = (j < 4) ? gpk_pkg::GLYPH_W'(j)
                                : 16'hFFFF - gpk_pkg::GLYPH_W'(7 - j);
        end else begin
          alphabet[j] = gpk_pkg::GLYPH_W'($urandom);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        add_op(gpk_pkg::OP_CLEAR);
      end
      n_pairs = $urandom_range(0, 24);
      run_keys.delete();
      for (int k = 0; k < n_pairs; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          key = $urandom;
        end else begin
          key = {alphabet[$urandom_range(0, 7)], alphabet[$urandom_range(0, 7)]};
        end
        run_keys.push_back(key);
      end
      if ($urandom_range(0, 9) != 0) begin
        run_keys.sort();
      end
      foreach (run_keys[k]) begin
        add_append(run_keys[k][31:16], run_keys[k][15:0], pick_value());
      end
      n_runs = $urandom_range(1, 4);
      for (int r = 0; r < n_runs; r++) begin
        run_len = $urandom_range(1, 8);
        for (int g = 0; g < run_len; g++) begin
          if ($urandom_range(0, 19) == 0) begin
            add_op(OP_UNUSED);
          end
          if ($urandom_range(0, 29) == 0) begin
            add_op(gpk_pkg::OP_CLEAR);
          end
          if ($urandom_range(0, 4) == 0) begin
            pick_glyph = gpk_pkg::GLYPH_W'($urandom);
          end else begin
            pick_glyph = alphabet[$urandom_range(0, 7)];
          end
          add_glyph(pick_glyph, pick_value(),
                    (g == run_len - 1) && ($urandom_range(0, 9) != 0));
        end
      end
    end
    total_requests = pending_requests.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_requests != total_requests) @(posedge clk);
    while (kerned_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gpk_pkg.sv
hw/rtl/gpk_ctrl.sv
hw/rtl/gpk_dp.sv
hw/rtl/glyph_pair_kerning_core.sv
hw/rtl/gpk_checker.sv
tb/glyph_pair_kerning_core_test.sv
